### sv/bpa_pkg.sv
// shared constants, codes and interface structs for the bitmap page allocator
// no dependencies; imported by every module of the block
package bpa_pkg;

    localparam int PAGES      = 4096;
    localparam int PAGE_W     = $clog2(PAGES) + 1;
    localparam int WORD_W     = 32;
    localparam int WORDS      = PAGES / WORD_W;
    localparam int WADDR_W    = $clog2(WORDS);
    localparam int WPTR_W     = WADDR_W + 1;
    localparam int WBIT_W     = $clog2(WORD_W);
    localparam int STEP_W     = 8;
    localparam int STEP_SEL_W = $clog2(WORD_W / STEP_W);
    localparam int SPTR_W     = $clog2(PAGES / STEP_W) + 1;
    localparam int ADDR_W     = 48;
    localparam int SHIFT_W    = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    localparam logic [PAGE_W-1:0]  COUNT_MAX = {PAGE_W{1'b1}};
    localparam logic [SHIFT_W-1:0] SHIFT_MIN = 5'd12;
    localparam logic [SHIFT_W-1:0] SHIFT_MAX = 5'd21;

    // request opcodes
    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_FREE    = 2'd1;
    localparam logic [1:0] OP_RELEASE = 2'd2;

    // result status
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_NOFIT = 2'd1;
    localparam logic [1:0] STAT_BAD   = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PAGE_SHIFT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PAGE_LIMIT = 1'b1;

    typedef struct packed {
        logic [STEP_W-1:0] bits;
        logic [PAGE_W-1:0] base;
        logic [PAGE_W-1:0] start;
        logic [PAGE_W-1:0] bound;
        logic [PAGE_W-1:0] count;
        logic [PAGE_W-1:0] run;
    } step_req_t;

    typedef struct packed {
        logic              found;
        logic [PAGE_W-1:0] end_pos;
        logic [PAGE_W-1:0] run;
    } step_rsp_t;

    typedef struct packed {
        logic               en;
        logic [WADDR_W-1:0] addr;
        logic [WORD_W-1:0]  data;
    } map_wr_t;

    typedef struct packed {
        logic               en;
        logic [WADDR_W-1:0] addr;
    } map_rd_t;

endpackage

### sv/bpa_map.sv
// used-page bitmap: word memory with one write and one registered read port
// row valid bits make unwritten rows read as all pages used; uses bpa_pkg
module bpa_map import bpa_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  map_wr_t           wr,
    input  map_rd_t           rd,
    output logic [WORD_W-1:0] rd_word
);

    logic [WORD_W-1:0] mem [WORDS];
    logic [WORD_W-1:0] rd_data_reg;
    logic [WORDS-1:0]  row_valid_reg;
    logic              rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.en) begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end else begin
            if (wr.en) begin
                row_valid_reg[wr.addr] <= 1'b1;
            end
            if (rd.en) begin
                rd_valid_reg <= row_valid_reg[rd.addr];
            end
        end
    end

    // never-written rows hold the reset state: every page used
    assign rd_word = rd_valid_reg ? rd_data_reg : '1;

endmodule

### sv/bpa_step.sv
// free-run search step: walks one byte of the bitmap, extending the run count
// and flagging the first page where the run reaches the request; uses bpa_pkg
module bpa_step import bpa_pkg::*; (
    input  step_req_t req,
    output step_rsp_t rsp
);

    logic [PAGE_W-1:0] run;
    logic [PAGE_W-1:0] pos;
    logic [PAGE_W-1:0] end_pos;
    logic              hit;

    always_comb begin
        run     = req.run;
        hit     = 1'b0;
        end_pos = '0;
        pos     = req.base;
        for (int j = 0; j < STEP_W; j++) begin
            pos = req.base + PAGE_W'(j);
            // pages outside the search window neither count nor break a run
            if (!hit && pos >= req.start && pos < req.bound) begin
                if (!req.bits[j]) begin
                    run = run + 1'b1;
                    if (run == req.count) begin
                        hit     = 1'b1;
                        end_pos = pos + 1'b1;
                    end
                end else begin
                    run = '0;
                end
            end
        end
        rsp.found   = hit;
        rsp.end_pos = end_pos;
        rsp.run     = run;
    end

endmodule

### sv/bitmap_page_allocator.sv
// One request is taken at a time; s_ready is high only while the block is idle,
// and a result may still sit in the output register when the next request is
// taken. A bad request goes straight from the check to completion. An allocate
// scans the used map one byte (8 pages) per cycle through a single run-search
// step, pausing for a read state before each 32-page word, over up to two
// passes (cursor to limit, then zero to the old cursor), then marks the run used
// a 32-page word at a time (read state, then write state). Free and release
// clear their range the same way. After reset the whole map reads as used at
// once; no clearing pass is needed. Depends on bpa_pkg, bpa_map, bpa_step.
module bitmap_page_allocator import bpa_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // requests
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_opcode,
    input  logic [PAGE_W-1:0]     s_page_count,
    input  logic [ADDR_W-1:0]     s_byte_address,
    // results
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [1:0]            m_status,
    output logic [ADDR_W-1:0]     m_run_address,
    output logic [PAGE_W-1:0]     m_used_pages
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CHECK  = 3'd1;
    localparam logic [2:0] ST_SSTART = 3'd2;
    localparam logic [2:0] ST_SRD    = 3'd3;
    localparam logic [2:0] ST_SSCAN  = 3'd4;
    localparam logic [2:0] ST_MRD    = 3'd5;
    localparam logic [2:0] ST_MWR    = 3'd6;
    localparam logic [2:0] ST_DONE   = 3'd7;

    logic [2:0]          state_reg, state_next;
    logic [SHIFT_W-1:0]  shift_reg, shift_next;
    logic [PAGE_W-1:0]   limit_reg, limit_next;
    logic [PAGE_W-1:0]   cursor_reg, cursor_next;
    logic [PAGE_W-1:0]   used_reg, used_next;
    logic                m_valid_reg, m_valid_next;

    logic [1:0]          op_reg, op_next;
    logic [PAGE_W-1:0]   count_reg, count_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic                pass_reg, pass_next;
    logic [PAGE_W-1:0]   start_reg, start_next;
    logic [PAGE_W-1:0]   bound_reg, bound_next;
    logic [PAGE_W-1:0]   bound2_reg, bound2_next;
    logic [PAGE_W-1:0]   run_reg, run_next;
    logic [SPTR_W-1:0]   byte_reg, byte_next;
    logic [PAGE_W-1:0]   lo_reg, lo_next;
    logic [PAGE_W-1:0]   hi_reg, hi_next;
    logic [WPTR_W-1:0]   wrd_reg, wrd_next;
    logic                set_reg, set_next;
    logic [1:0]          stat_reg, stat_next;
    logic [1:0]          m_status_reg, m_status_next;
    logic [ADDR_W-1:0]   m_addr_reg, m_addr_next;
    logic [PAGE_W-1:0]   m_used_reg, m_used_next;

    logic [PAGE_W-1:0]   lim;
    logic [SHIFT_W-1:0]  sh;
    logic [ADDR_W-1:0]   idx_full;
    logic                range_ok;
    logic [PAGE_W:0]     range_end;
    logic [PAGE_W-1:0]   bound2;
    logic [PAGE_W:0]     used_sum;
    logic [WORD_W-1:0]   rd_word;
    logic [WORD_W-1:0]   mask;
    logic [PAGE_W-1:0]   mask_pos;
    logic [SPTR_W-1:0]   byte_inc;
    logic [WPTR_W-1:0]   wrd_inc;
    logic [PAGE_W-1:0]   run_first;
    map_wr_t             map_wr;
    map_rd_t             map_rd;
    step_req_t           step_req;
    step_rsp_t           step_rsp;

    bpa_map u_map (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (map_wr),
        .rd      (map_rd),
        .rd_word (rd_word)
    );

    bpa_step u_step (
        .req (step_req),
        .rsp (step_rsp)
    );

    assign cfg_ready     = 1'b1;
    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_run_address = m_addr_reg;
    assign m_used_pages  = m_used_reg;

    assign lim = (limit_reg > PAGE_W'(PAGES)) ? PAGE_W'(PAGES) : limit_reg;
    assign sh  = (shift_reg < SHIFT_MIN) ? SHIFT_MIN :
                 (shift_reg > SHIFT_MAX) ? SHIFT_MAX : shift_reg;
    assign bound2 = (cursor_reg < lim) ? cursor_reg : lim;

    // page index of a free or release range and its bound check
    assign idx_full  = addr_reg >> sh;
    assign range_end = {1'b0, idx_full[PAGE_W-1:0]} + {1'b0, count_reg};
    assign range_ok  = (idx_full[ADDR_W-1:PAGE_W] == '0) && (range_end <= {1'b0, lim});

    assign byte_inc  = byte_reg + 1'b1;
    assign wrd_inc   = wrd_reg + 1'b1;
    assign run_first = step_rsp.end_pos - count_reg;
    assign used_sum  = {1'b0, used_reg} + {1'b0, count_reg};

    assign step_req.bits  = rd_word[{byte_reg[STEP_SEL_W-1:0], 3'b000} +: STEP_W];
    assign step_req.base  = {byte_reg, 3'b000};
    assign step_req.start = start_reg;
    assign step_req.bound = bound_reg;
    assign step_req.count = count_reg;
    assign step_req.run   = run_reg;

    // bits of the current word that fall inside [lo, hi)
    always_comb begin
        mask     = '0;
        mask_pos = '0;
        for (int j = 0; j < WORD_W; j++) begin
            mask_pos = {1'b0, wrd_reg[WADDR_W-1:0], {WBIT_W{1'b0}}} + PAGE_W'(j);
            mask[j]  = (mask_pos >= lo_reg) && (mask_pos < hi_reg);
        end
    end

    always_comb begin
        map_rd.en   = 1'b0;
        map_rd.addr = wrd_reg[WADDR_W-1:0];
        if (state_reg == ST_SRD) begin
            map_rd.en   = 1'b1;
            map_rd.addr = byte_reg[WADDR_W+STEP_SEL_W-1:STEP_SEL_W];
        end else if (state_reg == ST_MRD) begin
            map_rd.en = 1'b1;
        end
        map_wr.en   = (state_reg == ST_MWR);
        map_wr.addr = wrd_reg[WADDR_W-1:0];
        map_wr.data = set_reg ? (rd_word | mask) : (rd_word & ~mask);
    end

    always_comb begin
        state_next    = state_reg;
        shift_next    = shift_reg;
        limit_next    = limit_reg;
        cursor_next   = cursor_reg;
        used_next     = used_reg;
        m_valid_next  = m_valid_reg;
        op_next       = op_reg;
        count_next    = count_reg;
        addr_next     = addr_reg;
        pass_next     = pass_reg;
        start_next    = start_reg;
        bound_next    = bound_reg;
        bound2_next   = bound2_reg;
        run_next      = run_reg;
        byte_next     = byte_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        wrd_next      = wrd_reg;
        set_next      = set_reg;
        stat_next     = stat_reg;
        m_status_next = m_status_reg;
        m_addr_next   = m_addr_reg;
        m_used_next   = m_used_reg;

        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_PAGE_SHIFT: shift_next = cfg_data[SHIFT_W-1:0];
                REG_PAGE_LIMIT: limit_next = cfg_data[PAGE_W-1:0];
                default: ;
            endcase
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    op_next    = s_opcode;
                    count_next = s_page_count;
                    addr_next  = s_byte_address;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                stat_next = STAT_BAD;
                if (count_reg == '0) begin
                    state_next = ST_DONE;
                end else if (op_reg == OP_ALLOC) begin
                    bound2_next = bound2;
                    start_next  = cursor_reg;
                    bound_next  = lim;
                    pass_next   = 1'b0;
                    state_next  = ST_SSTART;
                end else if ((op_reg == OP_FREE || op_reg == OP_RELEASE)
                             && addr_reg != '0 && range_ok) begin
                    lo_next    = idx_full[PAGE_W-1:0];
                    hi_next    = range_end[PAGE_W-1:0];
                    wrd_next   = idx_full[PAGE_W-1:WBIT_W];
                    set_next   = 1'b0;
                    state_next = ST_MRD;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_SSTART: begin
                run_next  = '0;
                byte_next = start_reg[PAGE_W-1:3];
                if (start_reg < bound_reg) begin
                    state_next = ST_SRD;
                end else if (!pass_reg) begin
                    pass_next  = 1'b1;
                    start_next = '0;
                    bound_next = bound2_reg;
                end else begin
                    stat_next   = STAT_NOFIT;
                    cursor_next = bound2_reg;
                    state_next  = ST_DONE;
                end
            end
            ST_SRD: begin
                state_next = ST_SSCAN;
            end
            ST_SSCAN: begin
                if (step_rsp.found) begin
                    lo_next     = run_first;
                    hi_next     = step_rsp.end_pos;
                    wrd_next    = run_first[PAGE_W-1:WBIT_W];
                    cursor_next = step_rsp.end_pos;
                    set_next    = 1'b1;
                    state_next  = ST_MRD;
                end else begin
                    run_next  = step_rsp.run;
                    byte_next = byte_inc;
                    if ({byte_inc, 3'b000} >= bound_reg) begin
                        // this pass is exhausted
                        if (!pass_reg) begin
                            pass_next  = 1'b1;
                            start_next = '0;
                            bound_next = bound2_reg;
                            state_next = ST_SSTART;
                        end else begin
                            stat_next   = STAT_NOFIT;
                            cursor_next = bound2_reg;
                            state_next  = ST_DONE;
                        end
                    end else if (byte_inc[STEP_SEL_W-1:0] == '0) begin
                        state_next = ST_SRD;
                    end
                end
            end
            ST_MRD: begin
                state_next = ST_MWR;
            end
            ST_MWR: begin
                wrd_next = wrd_inc;
                if ({wrd_inc, {WBIT_W{1'b0}}} >= hi_reg) begin
                    stat_next  = STAT_OK;
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_MRD;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    used_next   = used_reg;
                    m_addr_next = '0;
                    if (stat_reg == STAT_OK && op_reg == OP_ALLOC) begin
                        used_next   = used_sum[PAGE_W] ? COUNT_MAX : used_sum[PAGE_W-1:0];
                        m_addr_next = ADDR_W'(lo_reg) << sh;
                    end else if (stat_reg == STAT_OK && op_reg == OP_FREE) begin
                        used_next = (used_reg > count_reg) ? (used_reg - count_reg) : '0;
                    end
                    m_used_next   = used_next;
                    m_status_next = stat_reg;
                    m_valid_next  = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            shift_reg   <= SHIFT_MIN;
            limit_reg   <= PAGE_W'(PAGES);
            cursor_reg  <= '0;
            used_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            shift_reg   <= shift_next;
            limit_reg   <= limit_next;
            cursor_reg  <= cursor_next;
            used_reg    <= used_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        count_reg    <= count_next;
        addr_reg     <= addr_next;
        pass_reg     <= pass_next;
        start_reg    <= start_next;
        bound_reg    <= bound_next;
        bound2_reg   <= bound2_next;
        run_reg      <= run_next;
        byte_reg     <= byte_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        wrd_reg      <= wrd_next;
        set_reg      <= set_next;
        stat_reg     <= stat_next;
        m_status_reg <= m_status_next;
        m_addr_reg   <= m_addr_next;
        m_used_reg   <= m_used_next;
    end

    // a new result beat is only ever loaded out of the completion state
    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result beat raised outside completion");

    // the cursor stays within the map
    a_cursor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cursor_reg <= PAGE_W'(PAGES))
        else $error("next-fit cursor beyond map");

    // scan pointer only addresses bytes inside the map
    a_scan_in_map: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SSCAN || state_reg == ST_SRD) |-> byte_reg < SPTR_W'(PAGES / STEP_W))
        else $error("scan pointer beyond map");

    // every word written back overlaps the range being marked or cleared
    a_write_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MWR) |-> (lo_reg < hi_reg && mask != '0))
        else $error("map write outside the target range");

    // a finished scan hands a non-empty range to the update loop
    a_found_to_update: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SSCAN && step_rsp.found) |=> (state_reg == ST_MRD && set_reg))
        else $error("found run not marked used");

endmodule
